// File: hw/rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

   // built depth of the ring and derived widths
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W = 5;
   localparam int CMP_W = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
   localparam int DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_POP_FRONT  = 2'd1,
      OP_PUSH_BACK  = 2'd2,
      OP_POP_BACK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // slot write command broadcast along the cell row
   typedef struct packed {
      logic     en;
      idx_type  idx;
      data_type data;
   } slot_wr_type;

endpackage

`default_nettype wire

// File: hw/rtl/cdq_if.sv
`default_nettype none

// request channel: one operation per transaction
interface cdq_req_if;
   import cdq_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   data_type   push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// response channel: one result per transaction
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic       valid;
   logic       ready;
   data_type   pop_value;
   status_type status;

   modport source (output valid, output pop_value, output status, input ready);
   modport sink (input valid, input pop_value, input status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/circular_double_ended_queue.sv
`default_nettype none

// Double-ended queue over a ring of DEPTH slot cells, of which the first
// csr capacity are in use (0 acts as 1, above DEPTH acts as DEPTH). Each
// request transaction pushes or pops at the front or back and yields exactly
// one response transaction with the popped value (zero otherwise) and a
// status of done, full or empty; refused operations leave the queue as is.
// A request is taken every clock cycle while the response register is free
// or being drained, and its response is registered and appears in the cycle
// after acceptance; the index update and the DEPTH-cell read chain are
// combinational. Capacity must be written only while idle; not enforced.
module circular_double_ended_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [cdq_pkg::CAP_W-1:0] csr_wdata,
   cdq_req_if.sink                       req_ch,
   cdq_rsp_if.source                     rsp_ch
);
   import cdq_pkg::*;

   idx_type          front_ff, front_in;
   idx_type          back_ff, back_in;
   logic             empty_ff, empty_in;
   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff;
   data_type         pop_value_ff, pop_value_in;
   status_type       status_ff, status_in;

   logic             accept;
   logic [CMP_W-1:0] cap_wide;
   logic [CMP_W-1:0] cap_eff;
   idx_type          cap_m1;
   idx_type          rd_idx;
   data_type         rd_data;
   idx_type          front_dn, front_up, back_dn, back_up;
   slot_wr_type      slot_wr;
   data_type         chain [DEPTH+1];

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;

   // effective capacity, clamped to one .. DEPTH
   always_comb begin
      cap_wide = CMP_W'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_wide > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = cap_wide;
      end
      cap_m1 = IDX_W'(cap_eff - CMP_W'(1));
   end

   // wrapped neighbors of both ends
   assign front_up = (front_ff >= cap_m1) ? '0 : front_ff + IDX_W'(1);
   assign front_dn = (front_ff == '0) ? cap_m1 : front_ff - IDX_W'(1);
   assign back_up  = (back_ff >= cap_m1) ? '0 : back_ff + IDX_W'(1);
   assign back_dn  = (back_ff == '0) ? cap_m1 : back_ff - IDX_W'(1);

   // row of slot cells with a read chain through them
   assign rd_idx   = (req_ch.opcode == OP_POP_FRONT) ? front_ff : back_ff;
   assign chain[0] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      cdq_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(g)),
         .slot_wr    (slot_wr),
         .rd_idx     (rd_idx),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1])
      );
   end

   assign rd_data = chain[DEPTH];

   // operation decode and next queue state
   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      empty_in     = empty_ff;
      pop_value_in = '0;
      status_in    = ST_DONE;
      slot_wr.en   = 1'b0;
      slot_wr.idx  = '0;
      slot_wr.data = req_ch.push_value;
      unique case (req_ch.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (empty_ff) begin
               front_in   = '0;
               back_in    = '0;
               empty_in   = 1'b0;
               slot_wr.en = accept;
            end else if (req_ch.opcode == OP_PUSH_FRONT) begin
               if (front_dn == back_ff) begin
                  status_in = ST_FULL;
               end else begin
                  front_in    = front_dn;
                  slot_wr.en  = accept;
                  slot_wr.idx = front_dn;
               end
            end else begin
               if (back_up == front_ff) begin
                  status_in = ST_FULL;
               end else begin
                  back_in     = back_up;
                  slot_wr.en  = accept;
                  slot_wr.idx = back_up;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty_ff) begin
               status_in = ST_EMPTY;
            end else begin
               pop_value_in = rd_data;
               if (front_ff == back_ff) begin
                  empty_in = 1'b1;
                  front_in = '0;
                  back_in  = '0;
               end else if (req_ch.opcode == OP_POP_FRONT) begin
                  front_in = front_up;
               end else begin
                  back_in = back_dn;
               end
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // queue control state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         empty_ff <= 1'b1;
         cap_ff   <= CAP_RESET;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            empty_ff <= empty_in;
         end
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_value_ff <= pop_value_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pop_value = pop_value_ff;
   assign rsp_ch.status    = status_ff;

`ifndef ASSERT_OFF
   // an empty queue parks both ends at slot zero
   a_empty_parked: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0 && back_ff == '0))
      else $error("empty queue with ends off slot zero");

   // a refused operation changes no queue state
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != ST_DONE) |=>
         ($stable(front_ff) && $stable(back_ff) && $stable(empty_ff)))
      else $error("refused operation moved the queue");

   // every accepted request leaves a pending response
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");

   // a pop refused for empty returns zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_EMPTY) |-> (pop_value_ff == '0))
      else $error("refused pop returned data");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cdq_cell.sv
`default_nettype none

module cdq_cell (
   input  wire logic                 clock,
   input  wire cdq_pkg::idx_type     cell_index,
   input  wire cdq_pkg::slot_wr_type slot_wr,
   input  wire cdq_pkg::idx_type     rd_idx,
   input  wire cdq_pkg::data_type    chain_in,
   output      cdq_pkg::data_type    chain_out
);
   import cdq_pkg::*;

   data_type slot_ff;

   // slot register, loaded when the write command targets this cell
   always_ff @(posedge clock) begin
      if (slot_wr.en && (slot_wr.idx == cell_index)) begin
         slot_ff <= slot_wr.data;
      end
   end

   // read chain: replace the passing value when this cell is addressed
   assign chain_out = (rd_idx == cell_index) ? slot_ff : chain_in;

endmodule

`default_nettype wire

// File: dv/tb_circular_double_ended_queue.sv
`default_nettype none

module tb_circular_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int BLOCK_ITEMS = 38;

   typedef struct packed {
      data_type   pop_value;
      status_type status;
   } deque_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CAP_W-1:0] csr_wdata;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_double_ended_queue dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // shadow copy of the deque
   data_type         shadow_slots [DEPTH];
   logic [DEPTH-1:0] slot_written;
   idx_type          shadow_front;
   idx_type          shadow_back;
   logic             shadow_empty;
   logic [CAP_W-1:0] shadow_cap;

   deque_result_type awaited_results [$];

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned src_idle_pct;
   int unsigned snk_stall_pct;
   int unsigned block_count;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  awaited_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(0, 99) >= snk_stall_pct);
   end

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // ring size in effect: 0 acts as 1, above the built depth acts as the depth
   function automatic int unsigned ring_size();
      int unsigned c;
      c = 32'(shadow_cap);
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic idx_type ring_up(idx_type i);
      return (int'(i) >= int'(ring_size()) - 1) ? idx_type'(0) : idx_type'(i + 1);
   endfunction

   function automatic idx_type ring_down(idx_type i);
      return (i == 0) ? idx_type'(ring_size() - 1) : idx_type'(i - 1);
   endfunction

   // apply one operation to the shadow deque and queue the result it yields
   function automatic void predict_deque_op(opcode_type op, data_type val);
      deque_result_type r;
      idx_type          n;
      r.pop_value = '0;
      r.status    = ST_DONE;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (shadow_empty) begin
            // first element always lands in slot 0
            shadow_front    = '0;
            shadow_back     = '0;
            shadow_slots[0] = val;
            slot_written[0] = 1'b1;
            shadow_empty    = 1'b0;
         end else if (op == OP_PUSH_FRONT) begin
            n = ring_down(shadow_front);
            if (n == shadow_back) begin
               r.status = ST_FULL;
            end else begin
               shadow_front    = n;
               shadow_slots[n] = val;
               slot_written[n] = 1'b1;
            end
         end else begin
            n = ring_up(shadow_back);
            if (n == shadow_front) begin
               r.status = ST_FULL;
            end else begin
               shadow_back     = n;
               shadow_slots[n] = val;
               slot_written[n] = 1'b1;
            end
         end
      end else begin
         if (shadow_empty) begin
            r.status = ST_EMPTY;
         end else begin
            r.pop_value = (op == OP_POP_FRONT) ? shadow_slots[shadow_front]
                                               : shadow_slots[shadow_back];
            if (shadow_front == shadow_back) begin
               // last element gone
               shadow_empty = 1'b1;
               shadow_front = '0;
               shadow_back  = '0;
            end else if (op == OP_POP_FRONT) begin
               shadow_front = ring_up(shadow_front);
            end else begin
               shadow_back = ring_down(shadow_back);
            end
         end
      end
      awaited_results.push_back(r);
   endfunction

   // send one operation; entered and left at a falling edge
   task automatic send_op(opcode_type op, data_type val);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.opcode     = op;
      req_bus.push_value = val;
      do @(posedge clock); while (!req_bus.ready);
      predict_deque_op(op, val);
      @(negedge clock);
   endtask

   // let every awaited result arrive, plus the pipeline latency
   task automatic wait_drain();
      req_bus.valid = 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] value);
      wait_drain();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      shadow_cap = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // pops on an empty deque are refused
   task automatic test_empty_pops();
      send_op(OP_POP_FRONT, data_type'($urandom));
      send_op(OP_POP_BACK, data_type'($urandom));
   endtask

   // extreme values through both ends, with front wrap at full capacity
   task automatic test_extreme_values();
      send_op(OP_PUSH_FRONT, 32'sh7fffffff);
      send_op(OP_POP_BACK, '0);
      send_op(OP_PUSH_BACK, 32'sh80000000);
      send_op(OP_PUSH_FRONT, 32'shffffffff);
      send_op(OP_PUSH_BACK, '0);
      send_op(OP_POP_FRONT, 32'sh7fffffff);
      send_op(OP_POP_BACK, 32'shffffffff);
      send_op(OP_POP_FRONT, '0);
   endtask

   // one-slot ring, then capacity zero acting as one
   task automatic test_small_capacity();
      set_capacity(CAP_W'(1));
      send_op(OP_PUSH_FRONT, data_type'($urandom));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      send_op(OP_PUSH_FRONT, data_type'($urandom));
      send_op(OP_POP_FRONT, data_type'($urandom));
      send_op(OP_POP_BACK, data_type'($urandom));
      set_capacity(CAP_W'(0));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      send_op(OP_PUSH_FRONT, data_type'($urandom));
      send_op(OP_POP_BACK, data_type'($urandom));
   endtask

   // shrink the ring while it holds data; contents stay where they are
   task automatic test_capacity_change_busy();
      set_capacity(CAP_W'(4));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      set_capacity(CAP_W'(2));
      send_op(OP_PUSH_BACK, data_type'($urandom));
      send_op(OP_POP_BACK, '0);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_POP_FRONT, '0);
   endtask

   function automatic data_type random_value();
      case ($urandom_range(0, 15))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return '0;
         3: return 32'shffffffff;
         default: return data_type'($urandom);
      endcase
   endfunction

   // random traffic in blocks, each at its own capacity; push-heavy then pop-heavy
   task automatic test_random_traffic(int unsigned src_pct, int unsigned snk_pct,
                                      int unsigned n_blocks);
      logic [CAP_W-1:0] extreme_caps [6];
      logic [CAP_W-1:0] cap;
      opcode_type       op;
      bit               is_push;
      bit               at_front;
      idx_type          rd_idx;
      extreme_caps  = '{CAP_W'(16), CAP_W'(1), CAP_W'(0), CAP_W'(31), CAP_W'(17), CAP_W'(2)};
      src_idle_pct  = src_pct;
      snk_stall_pct = snk_pct;
      for (int b = 0; b < n_blocks; b++) begin
         cap = (block_count < 6) ? extreme_caps[block_count] : CAP_W'($urandom_range(0, 31));
         block_count++;
         set_capacity(cap);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            is_push  = (i < 25) ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 99) < 20);
            at_front = 1'($urandom_range(0, 1));
            // after a shrink a pop may land on a slot never filled; push there instead
            if (!is_push && !shadow_empty) begin
               rd_idx = at_front ? shadow_front : shadow_back;
               if (!slot_written[rd_idx]) is_push = 1'b1;
            end
            if (is_push) op = at_front ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else op = at_front ? OP_POP_FRONT : OP_POP_BACK;
            send_op(op, random_value());
         end
      end
   endtask

   // compare each response with the oldest awaited result
   always @(posedge clock) begin : check_responses
      deque_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.pop_value !== want.pop_value)
               report_mismatch($sformatf("pop_value got %h want %h",
                                         rsp_bus.pop_value, want.pop_value));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status got %s want %s",
                                         rsp_bus.status.name(), want.status.name()));
         end
      end
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_PUSH_FRONT;
      req_bus.push_value = '0;
      rsp_bus.ready      = 1'b0;
      cycle_count        = 0;
      mismatch_count     = 0;
      src_idle_pct       = 0;
      snk_stall_pct      = 0;
      block_count        = 0;
      shadow_front       = '0;
      shadow_back        = '0;
      shadow_empty       = 1'b1;
      shadow_cap         = CAP_RESET;
      slot_written       = '0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_pops();
      test_extreme_values();
      test_small_capacity();
      test_capacity_change_busy();

      test_random_traffic(0, 0, 3);
      test_random_traffic(69, 0, 3);
      test_random_traffic(0, 69, 3);
      test_random_traffic(33, 33, 3);

      wait_drain();
      if (awaited_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
